FILE: rtl/core/tcsg_pkg.sv
// shared types and constants of the three-channel sound generator
// depends on nothing; every other file of the block except tcsg_tone refers to it by scoped names
package tcsg_pkg;

    // register slots kept on the bus, mixed or not
    localparam int CH_SLOTS = 3;

    localparam int SAMPLE_W = 13;
    localparam int SUM_W    = 16;
    localparam int LFSR_W   = 17;
    localparam int VOL_ENV_BIT = 4;

    localparam logic [LFSR_W-1:0] LFSR_RESET = 17'h1FFFF;
    localparam logic [3:0]        LEVEL_MAX  = 4'd15;

    // item kinds
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // bus address map
    localparam logic [3:0] ADDR_TONE0_LO = 4'd0;
    localparam logic [3:0] ADDR_TONE0_HI = 4'd1;
    localparam logic [3:0] ADDR_TONE1_LO = 4'd2;
    localparam logic [3:0] ADDR_TONE1_HI = 4'd3;
    localparam logic [3:0] ADDR_TONE2_LO = 4'd4;
    localparam logic [3:0] ADDR_TONE2_HI = 4'd5;
    localparam logic [3:0] ADDR_NOISE    = 4'd6;
    localparam logic [3:0] ADDR_MIXER    = 4'd7;
    localparam logic [3:0] ADDR_VOL0     = 4'd8;
    localparam logic [3:0] ADDR_VOL1     = 4'd9;
    localparam logic [3:0] ADDR_VOL2     = 4'd10;
    localparam logic [3:0] ADDR_ENV_LO   = 4'd11;
    localparam logic [3:0] ADDR_ENV_HI   = 4'd12;
    localparam logic [3:0] ADDR_SHAPE    = 4'd13;
    localparam logic [3:0] ADDR_LEVEL    = 4'd14;

    // envelope shapes; anything above triangle runs as sawtooth
    localparam logic [7:0] SHAPE_OFF      = 8'd0;
    localparam logic [7:0] SHAPE_ATTACK   = 8'd1;
    localparam logic [7:0] SHAPE_DECAY    = 8'd2;
    localparam logic [7:0] SHAPE_TRIANGLE = 8'd3;

    // command broadcast to the generator units for the word in execution
    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [3:0] addr;
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: rtl/core/tcsg_ifs.sv
// valid/ready channel interfaces of the sound generator: request and response
// depends on tcsg_pkg for the sample width
interface tcsg_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] reg_address;
    logic [7:0] write_data;

    modport source (output valid, output func, output reg_address, output write_data,
                    input ready);
    modport sink   (input valid, input func, input reg_address, input write_data,
                    output ready);
endinterface

interface tcsg_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcsg_pkg::SAMPLE_W-1:0] sample;
    logic [7:0]                    read_data;

    modport source (output valid, output sample, output read_data, input ready);
    modport sink   (input valid, input sample, input read_data, output ready);
endinterface

FILE: rtl/core/tcsg_tone.sv
// one square-wave tone divider: down counter reloaded from the period
// depends on nothing beyond its ports
module tcsg_tone
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic [15:0] period,
    output logic        tone_now
);

    logic [15:0] count_reg, count_next;
    logic        bit_reg, bit_next;
    logic [15:0] count_dec;

    always_comb
    begin
        count_dec  = count_reg - 16'd1;
        count_next = count_reg;
        bit_next   = bit_reg;
        if (tick && period != 16'd0)
        begin
            count_next = count_dec;
            if (count_dec == 16'd0)
            begin
                count_next = period;
                bit_next   = ~bit_reg;
            end
        end
    end

    // mixer sees the bit after this tick's toggle
    assign tone_now = bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
            bit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

FILE: rtl/core/tcsg_noise.sv
// noise divider and 17-bit lfsr, with the divisor register
// depends on tcsg_pkg for the command struct and address codes
module tcsg_noise
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tcsg_pkg::cmd_t               cmd,
    output logic [7:0]                   divisor,
    output logic                         noise_bit
);

    logic [7:0]                  div_reg, div_next;
    logic [7:0]                  count_reg, count_next;
    logic [tcsg_pkg::LFSR_W-1:0] shift_reg, shift_next;
    logic                        bit_reg, bit_next;
    logic [7:0]                  count_dec;
    logic                        step;

    always_comb
    begin
        div_next   = div_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        count_dec  = count_reg - 8'd1;
        step       = 1'b0;
        if (cmd.tick)
        begin
            if (div_reg == 8'd0)
            begin
                count_next = 8'd1;
                step       = 1'b1;
            end
            else if (count_dec == 8'd0)
            begin
                count_next = div_reg;
                step       = 1'b1;
            end
            else
            begin
                count_next = count_dec;
            end
        end
        if (step)
        begin
            bit_next   = shift_reg[0];
            shift_next = {shift_reg[0] ^ shift_reg[3], shift_reg[tcsg_pkg::LFSR_W-1:1]};
        end
        if (cmd.wr && cmd.addr == tcsg_pkg::ADDR_NOISE)
        begin
            div_next   = cmd.data;
            count_next = 8'd1;
        end
    end

    assign divisor   = div_reg;
    assign noise_bit = bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg   <= 8'd0;
            count_reg <= 8'd1;
            shift_reg <= tcsg_pkg::LFSR_RESET;
            bit_reg   <= 1'b0;
        end
        else
        begin
            div_reg   <= div_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

FILE: rtl/core/tcsg_env.sv
// envelope generator: period, shape and level registers with the step logic
// depends on tcsg_pkg for the command struct, address and shape codes
module tcsg_env
(
    input  logic           clk,
    input  logic           rst_n,
    input  tcsg_pkg::cmd_t cmd,
    output logic [15:0]    period,
    output logic [7:0]     shape,
    output logic [3:0]     level
);

    logic [15:0] period_reg, period_next;
    logic [7:0]  shape_reg, shape_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  level_reg, level_next;
    logic        falling_reg, falling_next;
    logic        started_reg, started_next;
    logic [15:0] count_dec;

    always_comb
    begin
        period_next  = period_reg;
        shape_next   = shape_reg;
        count_next   = count_reg;
        level_next   = level_reg;
        falling_next = falling_reg;
        started_next = started_reg;
        count_dec    = count_reg - 16'd1;

        if (cmd.tick)
        begin
            if (shape_reg == tcsg_pkg::SHAPE_OFF || period_reg == 16'd0)
            begin
                level_next = tcsg_pkg::LEVEL_MAX;
            end
            else
            begin
                count_next = count_dec;
                if (count_dec == 16'd0)
                begin
                    count_next = period_reg;
                    if (!started_reg)
                    begin
                        // first step after a restart sets the starting point
                        started_next = 1'b1;
                        if (shape_reg == tcsg_pkg::SHAPE_DECAY)
                        begin
                            level_next   = tcsg_pkg::LEVEL_MAX;
                            falling_next = 1'b1;
                        end
                        else
                        begin
                            level_next   = 4'd0;
                            falling_next = 1'b0;
                        end
                    end
                    else
                    begin
                        case (shape_reg)
                            tcsg_pkg::SHAPE_ATTACK:
                            begin
                                if (level_reg != tcsg_pkg::LEVEL_MAX)
                                    level_next = level_reg + 4'd1;
                            end
                            tcsg_pkg::SHAPE_DECAY:
                            begin
                                if (level_reg != 4'd0)
                                    level_next = level_reg - 4'd1;
                            end
                            tcsg_pkg::SHAPE_TRIANGLE:
                            begin
                                if (falling_reg)
                                begin
                                    if (level_reg == 4'd0)
                                    begin
                                        level_next   = 4'd1;
                                        falling_next = 1'b0;
                                    end
                                    else
                                        level_next = level_reg - 4'd1;
                                end
                                else
                                begin
                                    if (level_reg == tcsg_pkg::LEVEL_MAX)
                                    begin
                                        level_next   = 4'd14;
                                        falling_next = 1'b1;
                                    end
                                    else
                                        level_next = level_reg + 4'd1;
                                end
                            end
                            // sawtooth and unknown shapes wrap around
                            default: level_next = level_reg + 4'd1;
                        endcase
                    end
                end
            end
        end

        if (cmd.wr)
        begin
            unique case (cmd.addr)
                tcsg_pkg::ADDR_ENV_LO: period_next = {period_reg[15:8], cmd.data};
                tcsg_pkg::ADDR_ENV_HI: period_next = {cmd.data, period_reg[7:0]};
                tcsg_pkg::ADDR_SHAPE:
                begin
                    shape_next   = cmd.data;
                    started_next = 1'b0;
                    count_next   = 16'd1;
                end
                tcsg_pkg::ADDR_LEVEL: level_next = cmd.data[3:0];
                default: ;
            endcase
        end
    end

    assign period = period_reg;
    assign shape  = shape_reg;
    assign level  = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= 16'd0;
            shape_reg   <= tcsg_pkg::SHAPE_OFF;
            count_reg   <= 16'd1;
            level_reg   <= tcsg_pkg::LEVEL_MAX;
            falling_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            period_reg  <= period_next;
            shape_reg   <= shape_next;
            count_reg   <= count_next;
            level_reg   <= level_next;
            falling_reg <= falling_next;
            started_reg <= started_next;
        end
    end

endmodule

FILE: rtl/core/three_channel_sound_generator_core.sv
// top level of the three-channel sound generator: input stage, register file,
// mixer and response register; depends on tcsg_pkg, tcsg_ifs, tcsg_tone,
// tcsg_noise and tcsg_env
//
// usage
//   req carries one word per item: func selects a sample tick, a register byte
//   write or a register byte read, with reg_address and write_data.
//   rsp returns exactly one word per request word: sample (nonzero only on a
//   tick) and read_data (the register byte on a read, else zero).
//   a word taken on req is registered in the input stage, is executed when
//   it moves into the response register, and shows on rsp the cycle after;
//   so a req handshake reaches rsp valid through the input stage and the
//   response register.
//   throughput is one word per cycle while rsp does not stall: all channels,
//   the noise unit and the envelope update together in the single execute
//   step, the only loop being the per-channel mixer adder chain.
//   when rsp is stalled the response holds, the input stage keeps one more
//   word, and req drops ready only while both are full.
//   reset (rst_n low, asynchronous) empties both stages and returns every
//   generator register to its power-up value: envelope level 15, lfsr all
//   ones, counters reloaded, periods and volumes zero.
module three_channel_sound_generator_core
#(
    parameter int NUM_CHANNELS   = 3,
    parameter int FULL_AMPLITUDE = 2000
)
(
    input  logic            clk,
    input  logic            rst_n,
    tcsg_req_if.sink        req,
    tcsg_rsp_if.source      rsp
);

    localparam int AMP_W = $clog2(FULL_AMPLITUDE + 1);

    // input stage
    logic       stg_valid_reg;
    logic [1:0] stg_func_reg;
    logic [3:0] stg_addr_reg;
    logic [7:0] stg_data_reg;

    // response register
    logic                          out_valid_reg;
    logic [tcsg_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [7:0]                    out_read_reg, out_read_next;

    logic out_free;
    logic exec;
    tcsg_pkg::cmd_t cmd;

    // bus registers held here
    logic [15:0] period_reg [tcsg_pkg::CH_SLOTS];
    logic [15:0] period_next [tcsg_pkg::CH_SLOTS];
    logic [7:0]  vol_reg [tcsg_pkg::CH_SLOTS];
    logic [7:0]  vol_next [tcsg_pkg::CH_SLOTS];
    logic [7:0]  mixer_reg, mixer_next;

    // unit outputs
    logic [NUM_CHANNELS-1:0] tone_now;
    logic [7:0]              noise_div;
    logic                    noise_bit;
    logic [15:0]             eg_period;
    logic [7:0]              eg_shape;
    logic [3:0]              eg_level;

    logic [AMP_W-1:0]           amp_lut [16];
    logic [tcsg_pkg::SUM_W-1:0] mix;

    // handshake: the stage moves forward when the response slot frees up
    assign out_free  = !out_valid_reg || rsp.ready;
    assign exec      = stg_valid_reg && out_free;
    assign req.ready = !stg_valid_reg || out_free;

    assign cmd.tick = exec && stg_func_reg == tcsg_pkg::FUNC_TICK;
    assign cmd.wr   = exec && stg_func_reg == tcsg_pkg::FUNC_WRITE;
    assign cmd.addr = stg_addr_reg;
    assign cmd.data = stg_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (req.valid && req.ready)
            stg_valid_reg <= 1'b1;
        else if (exec)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stg_func_reg <= req.func;
            stg_addr_reg <= req.reg_address;
            stg_data_reg <= req.write_data;
        end
    end

    // tone dividers exist only for mixed channels; their state is not readable
    for (genvar ch = 0; ch < NUM_CHANNELS; ch++)
    begin : g_tone
        tcsg_tone u_tone
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (cmd.tick),
            .period   (period_reg[ch]),
            .tone_now (tone_now[ch])
        );
    end

    tcsg_noise u_noise
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .divisor   (noise_div),
        .noise_bit (noise_bit)
    );

    tcsg_env u_env
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .period (eg_period),
        .shape  (eg_shape),
        .level  (eg_level)
    );

    // amplitude per volume step, worked out at elaboration
    for (genvar v = 0; v < 16; v++)
    begin : g_amp
        localparam int AMP_V = FULL_AMPLITUDE * v / 15;
        assign amp_lut[v] = AMP_W'(AMP_V);
    end

    // register file writes
    always_comb
    begin
        period_next = period_reg;
        vol_next    = vol_reg;
        mixer_next  = mixer_reg;
        if (cmd.wr)
        begin
            unique case (cmd.addr)
                tcsg_pkg::ADDR_TONE0_LO: period_next[0] = {period_reg[0][15:8], cmd.data};
                tcsg_pkg::ADDR_TONE0_HI: period_next[0] = {cmd.data, period_reg[0][7:0]};
                tcsg_pkg::ADDR_TONE1_LO: period_next[1] = {period_reg[1][15:8], cmd.data};
                tcsg_pkg::ADDR_TONE1_HI: period_next[1] = {cmd.data, period_reg[1][7:0]};
                tcsg_pkg::ADDR_TONE2_LO: period_next[2] = {period_reg[2][15:8], cmd.data};
                tcsg_pkg::ADDR_TONE2_HI: period_next[2] = {cmd.data, period_reg[2][7:0]};
                tcsg_pkg::ADDR_MIXER:    mixer_next     = cmd.data;
                tcsg_pkg::ADDR_VOL0:     vol_next[0]    = cmd.data;
                tcsg_pkg::ADDR_VOL1:     vol_next[1]    = cmd.data;
                tcsg_pkg::ADDR_VOL2:     vol_next[2]    = cmd.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tcsg_pkg::CH_SLOTS; i++)
            begin
                period_reg[i] <= 16'd0;
                vol_reg[i]    <= 8'd0;
            end
            mixer_reg <= 8'd0;
        end
        else
        begin
            period_reg <= period_next;
            vol_reg    <= vol_next;
            mixer_reg  <= mixer_next;
        end
    end

    // mixer: new tone bit, old noise bit, old envelope level
    always_comb
    begin
        logic       on;
        logic [3:0] v;
        mix = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            on = (mixer_reg[ch] & tone_now[ch]) | (mixer_reg[ch + 3] & noise_bit);
            v  = vol_reg[ch][tcsg_pkg::VOL_ENV_BIT] ? eg_level : vol_reg[ch][3:0];
            if (on)
                mix = mix + tcsg_pkg::SUM_W'(amp_lut[v]);
        end
    end

    // response word; the sum is truncated to the 13-bit sample width, with no clamp
    always_comb
    begin
        out_sample_next = '0;
        out_read_next   = 8'd0;
        if (stg_func_reg == tcsg_pkg::FUNC_TICK)
            out_sample_next = mix[tcsg_pkg::SAMPLE_W-1:0];
        else if (stg_func_reg == tcsg_pkg::FUNC_READ)
        begin
            unique case (stg_addr_reg)
                tcsg_pkg::ADDR_TONE0_LO: out_read_next = period_reg[0][7:0];
                tcsg_pkg::ADDR_TONE0_HI: out_read_next = period_reg[0][15:8];
                tcsg_pkg::ADDR_TONE1_LO: out_read_next = period_reg[1][7:0];
                tcsg_pkg::ADDR_TONE1_HI: out_read_next = period_reg[1][15:8];
                tcsg_pkg::ADDR_TONE2_LO: out_read_next = period_reg[2][7:0];
                tcsg_pkg::ADDR_TONE2_HI: out_read_next = period_reg[2][15:8];
                tcsg_pkg::ADDR_NOISE:    out_read_next = noise_div;
                tcsg_pkg::ADDR_MIXER:    out_read_next = mixer_reg;
                tcsg_pkg::ADDR_VOL0:     out_read_next = vol_reg[0];
                tcsg_pkg::ADDR_VOL1:     out_read_next = vol_reg[1];
                tcsg_pkg::ADDR_VOL2:     out_read_next = vol_reg[2];
                tcsg_pkg::ADDR_ENV_LO:   out_read_next = eg_period[7:0];
                tcsg_pkg::ADDR_ENV_HI:   out_read_next = eg_period[15:8];
                tcsg_pkg::ADDR_SHAPE:    out_read_next = eg_shape;
                tcsg_pkg::ADDR_LEVEL:    out_read_next = {4'd0, eg_level};
                default:                 out_read_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_sample_reg <= out_sample_next;
            out_read_reg   <= out_read_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.sample    = out_sample_reg;
    assign rsp.read_data = out_read_reg;

`ifndef ASSERT_OFF
    // an executed word always lands in the response register
    a_exec_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> rsp.valid)
        else $error("executed word did not reach the response");

    // a word never carries both a sample and read data
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.read_data != 8'd0 |-> rsp.sample == '0)
        else $error("response carries sample and read data together");

    // an empty input stage never blocks the request side
    a_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_valid_reg |-> req.ready)
        else $error("request stalled with an empty input stage");

    // a stalled response is not overwritten by a new execution
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !exec)
        else $error("response overwritten while stalled");
`endif

endmodule
